>>> design/paletted_tile_pixel_decoder_core_assert.svh
// Assertion macros for the paletted tile pixel decoder core.
`ifndef PALETTED_TILE_PIXEL_DECODER_CORE_ASSERT_SVH
`define PALETTED_TILE_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTD_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ptd assertion failed");

// Next-cycle implication, checked outside reset.
`define PTD_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ptd assertion failed");

`endif

>>> design/ptd_pkg.sv
// Package with the constants, codes and types of the paletted tile pixel decoder.
package ptd_pkg;

    // Video memory size in bytes; a power of two between 4096 and 131072.
    localparam int VRAM_BYTES = 65536;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    // Width of the address sum: 16-bit base plus a 16-bit tile offset and row offset.
    localparam int ADDR_SUM_W = 18;

    localparam int PAL_DEPTH  = 512;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);

    localparam logic [15:0] TRANSPARENT_RESET = 16'h8000;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] ACT_WR_VRAM  = 2'd0;
    localparam logic [1:0] ACT_WR_PAL   = 2'd1;
    localparam logic [1:0] ACT_DEC_BG   = 2'd2;
    localparam logic [1:0] ACT_DEC_OBJ  = 2'd3;

    // Decode context handed to the address unit for the current pixel.
    typedef struct packed {
        logic [15:0] base;
        logic [9:0]  tnum;
        logic [3:0]  bank;
        logic        eight;
        logic        obj;
        logic [2:0]  row;
        logic [2:0]  x;
    } ptd_ctx_t;

    // Results of the address unit.
    typedef struct packed {
        logic [VRAM_AW-1:0] vram_addr;
        logic [PAL_AW-1:0]  pal_addr;
        logic               idx_zero;
    } ptd_agu_t;

endpackage

>>> design/paletted_tile_pixel_decoder_core.sv
// Paletted tile pixel decoder: a write to video memory or palette is taken while idle and
// produces no item. A background row decode keeps the input not ready after it is taken
// while each of its eight pixels passes through a video memory read, a palette read and a
// result load in turn; an object decode does the same for its single pixel. Any output stall
// holds the result load and so adds to both. The pace is set by the one read port of each
// memory, used once per pixel in turn, and the input is not ready until the last result of
// a decode is loaded into the output register. Both memories power up undefined and need
// no clearing pass.
module paletted_tile_pixel_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // transparent_colour
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: write_address[15:0], write_data[31:16], tile_addr[47:32],
    // tile_idx[57:48], palette_bank[61:58], eight_bpp[62], pixel_x[65:63],
    // pixel_y[68:66], hflip[69], vflip[70], zero pad[71]
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,        // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // colour[15:0], column[18:16], zero pad[23:19]
    output logic        m_tlast         // last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_VRD  = 2'd1;
    localparam logic [1:0] S_PRD  = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  col_reg, col_next;
    logic [15:0] transparent_reg;
    logic        zero_reg;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_colour_reg;
    logic [2:0]  out_col_reg;
    logic        out_last_reg;

    // Decode context, held for the whole decode.
    logic [15:0] base_reg;
    logic [9:0]  tnum_reg;
    logic [3:0]  bank_reg;
    logic        eight_reg;
    logic        obj_reg;
    logic [2:0]  px_reg;
    logic [2:0]  row_reg;
    logic        hflip_reg;

    logic        in_accept;
    logic        vram_we;
    logic        pal_we;
    logic        out_load;
    logic        pix_last;
    logic [ptd_pkg::ADDR_SUM_W-1:0] wr_addr_ext;

    logic [7:0]  vram_rdata;
    logic [15:0] pal_rdata;

    ptd_pkg::ptd_ctx_t ctx;
    ptd_pkg::ptd_agu_t agu;

    assign in_accept   = s_tvalid && s_tready;
    assign s_tready    = (state_reg == S_IDLE);
    assign vram_we     = in_accept && (s_tuser == ptd_pkg::ACT_WR_VRAM);
    assign pal_we      = in_accept && (s_tuser == ptd_pkg::ACT_WR_PAL);
    assign wr_addr_ext = ptd_pkg::ADDR_SUM_W'(s_tdata[15:0]);

    assign pix_last = obj_reg || (col_reg == 3'd7);
    assign out_load = (state_reg == S_RES) && (!out_valid_reg || m_tready);

    always_comb
    begin
        ctx.base  = base_reg;
        ctx.tnum  = tnum_reg;
        ctx.bank  = bank_reg;
        ctx.eight = eight_reg;
        ctx.obj   = obj_reg;
        ctx.row   = row_reg;
        ctx.x     = obj_reg ? px_reg : (col_reg ^ {3{hflip_reg}});
    end

    ptd_agu u_agu (
        .ctx       (ctx),
        .vram_byte (vram_rdata),
        .res       (agu)
    );

    ptd_ram #(
        .WIDTH (8),
        .DEPTH (ptd_pkg::VRAM_BYTES)
    ) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (wr_addr_ext[ptd_pkg::VRAM_AW-1:0]),
        .wdata (s_tdata[23:16]),
        .re    (state_reg == S_VRD),
        .raddr (agu.vram_addr),
        .rdata (vram_rdata)
    );

    ptd_ram #(
        .WIDTH (16),
        .DEPTH (ptd_pkg::PAL_DEPTH)
    ) u_pal (
        .clk   (clk),
        .we    (pal_we),
        .waddr (s_tdata[ptd_pkg::PAL_AW-1:0]),
        .wdata (s_tdata[31:16]),
        .re    (state_reg == S_PRD),
        .raddr (agu.pal_addr),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                col_next = 3'd0;
                if (in_accept && (s_tuser == ptd_pkg::ACT_DEC_BG ||
                                  s_tuser == ptd_pkg::ACT_DEC_OBJ))
                begin
                    state_next = S_VRD;
                end
            end
            S_VRD:
            begin
                state_next = S_PRD;
            end
            S_PRD:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                // The palette data stays in its read register until the slot frees.
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (pix_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 3'd1;
                        state_next = S_VRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            col_reg         <= 3'd0;
            out_valid_reg   <= 1'b0;
            transparent_reg <= ptd_pkg::TRANSPARENT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                transparent_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            base_reg  <= s_tdata[47:32];
            tnum_reg  <= s_tdata[57:48];
            bank_reg  <= s_tdata[61:58];
            eight_reg <= s_tdata[62];
            px_reg    <= s_tdata[65:63];
            obj_reg   <= (s_tuser == ptd_pkg::ACT_DEC_OBJ);
            hflip_reg <= s_tdata[69] && (s_tuser == ptd_pkg::ACT_DEC_BG);
            // Vertical flip applies to background rows only.
            row_reg   <= s_tdata[68:66] ^
                         {3{s_tdata[70] && (s_tuser == ptd_pkg::ACT_DEC_BG)}};
        end
        if (state_reg == S_PRD)
        begin
            zero_reg <= agu.idx_zero;
        end
        if (out_load)
        begin
            out_colour_reg <= zero_reg ? transparent_reg : pal_rdata;
            out_col_reg    <= obj_reg ? px_reg : col_reg;
            out_last_reg   <= pix_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_col_reg, out_colour_reg};
    assign m_tlast  = out_last_reg;

`include "paletted_tile_pixel_decoder_core_assert.svh"

    `PTD_ASSERT_NOW(a_mem_wr_idle, (vram_we || pal_we), (state_reg == S_IDLE))
    `PTD_ASSERT_NOW(a_obj_single_pixel, (state_reg != S_IDLE && obj_reg), (col_reg == 3'd0))
    `PTD_ASSERT_NEXT(a_last_ends_decode, (out_load && pix_last), (s_tready && m_tvalid && m_tlast))

endmodule

>>> design/ptd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ptd_agu.sv
// Shared address unit: video memory byte address and palette entry of one pixel.
module ptd_agu (
    input  ptd_pkg::ptd_ctx_t ctx,
    input  logic [7:0]        vram_byte,
    output ptd_pkg::ptd_agu_t res
);

    logic [ptd_pkg::ADDR_SUM_W-1:0] tile_off;
    logic [ptd_pkg::ADDR_SUM_W-1:0] pix_off;
    logic [ptd_pkg::ADDR_SUM_W-1:0] addr_sum;
    logic [7:0]                     idx;

    always_comb
    begin
        // Objects address the tile directly; background rows add the tile index.
        if (ctx.obj)
        begin
            tile_off = '0;
        end
        else if (ctx.eight)
        begin
            tile_off = ptd_pkg::ADDR_SUM_W'({ctx.tnum, 6'b0});
        end
        else
        begin
            tile_off = ptd_pkg::ADDR_SUM_W'({ctx.tnum, 5'b0});
        end

        if (ctx.eight)
        begin
            pix_off = ptd_pkg::ADDR_SUM_W'({ctx.row, ctx.x});
        end
        else
        begin
            pix_off = ptd_pkg::ADDR_SUM_W'({ctx.row, ctx.x[2:1]});
        end

        addr_sum      = ptd_pkg::ADDR_SUM_W'(ctx.base) + tile_off + pix_off;
        res.vram_addr = addr_sum[ptd_pkg::VRAM_AW-1:0];

        // At 4bpp the odd column sits in the high nibble.
        if (ctx.eight)
        begin
            idx          = vram_byte;
            res.pal_addr = {ctx.obj, vram_byte};
        end
        else
        begin
            idx          = ctx.x[0] ? {4'b0, vram_byte[7:4]} : {4'b0, vram_byte[3:0]};
            res.pal_addr = {ctx.obj, ctx.bank, idx[3:0]};
        end
        res.idx_zero = (idx == 8'd0);
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the paletted tile pixel decoder core.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic [15:0] tile_addr;
        logic [9:0]  tile_idx;
        logic [3:0]  palette_bank;
        logic        eight_bpp;
        logic [2:0]  pixel_x;
        logic [2:0]  pixel_y;
        logic        hflip;
        logic        vflip;
    } decode_item_t;

    typedef struct packed {
        logic [15:0] colour;
        logic [2:0]  column;
        logic        last;
    } pixel_t;

    // Shadow of both memories and the transparent colour, plus the queue of pixels owed.
    class pixel_scoreboard;
        logic [7:0]  vram_mem [ptd_pkg::VRAM_BYTES];
        logic [15:0] pal_mem [ptd_pkg::PAL_DEPTH];
        logic [15:0] transparent_colour;
        pixel_t      expected_pixels [$];
        int          mismatches;
        int          pixels_checked;
        int          rows_decoded;
        int          objects_decoded;

        function new();
            transparent_colour = ptd_pkg::TRANSPARENT_RESET;
            mismatches = 0;
            pixels_checked = 0;
            rows_decoded = 0;
            objects_decoded = 0;
        endfunction

        // Video memory byte that feeds screen column col of a decode.
        function int source_address(decode_item_t it, int col);
            int row;
            int x;
            int addr;
            if (it.action == ptd_pkg::ACT_DEC_OBJ)
            begin
                if (it.eight_bpp)
                    addr = int'(it.tile_addr) + 8 * int'(it.pixel_y) + int'(it.pixel_x);
                else
                    addr = int'(it.tile_addr) + 4 * int'(it.pixel_y) + int'(it.pixel_x >> 1);
            end
            else
            begin
                row = it.vflip ? (int'(it.pixel_y) ^ 7) : int'(it.pixel_y);
                x = it.hflip ? (col ^ 7) : col;
                if (it.eight_bpp)
                    addr = int'(it.tile_addr) + 64 * int'(it.tile_idx) + 8 * row + x;
                else
                    addr = int'(it.tile_addr) + 32 * int'(it.tile_idx) + 4 * row + x / 2;
            end
            return addr % ptd_pkg::VRAM_BYTES;
        endfunction

        // Pixel index and palette entry for screen column col, from the shadow memory.
        function void palette_source(decode_item_t it, int col, output int index,
                                     output int entry);
            logic [7:0] b;
            int         x;
            int         offset;
            b = vram_mem[source_address(it, col)];
            if (it.action == ptd_pkg::ACT_DEC_OBJ)
                x = int'(it.pixel_x);
            else
                x = it.hflip ? (col ^ 7) : col;
            if (it.eight_bpp)
            begin
                index = int'(b);
                offset = 0;
            end
            else
            begin
                index = (x & 1) ? int'(b[7:4]) : int'(b[3:0]);
                offset = 16 * int'(it.palette_bank);
            end
            if (it.action == ptd_pkg::ACT_DEC_OBJ)
                offset = offset + 256;
            entry = (offset + index) % ptd_pkg::PAL_DEPTH;
        endfunction

        function pixel_t decoded_pixel(decode_item_t it, int col);
            pixel_t p;
            int     index;
            int     entry;
            palette_source(it, col, index, entry);
            p.colour = (index == 0) ? transparent_colour : pal_mem[entry];
            if (it.action == ptd_pkg::ACT_DEC_OBJ)
            begin
                p.column = it.pixel_x;
                p.last = 1'b1;
            end
            else
            begin
                p.column = col[2:0];
                p.last = (col == 7);
            end
            return p;
        endfunction

        function void note_item(decode_item_t it);
            case (it.action)
                ptd_pkg::ACT_WR_VRAM:
                begin
                    vram_mem[int'(it.write_address) % ptd_pkg::VRAM_BYTES] = it.write_data[7:0];
                end
                ptd_pkg::ACT_WR_PAL:
                begin
                    pal_mem[it.write_address[ptd_pkg::PAL_AW-1:0]] = it.write_data;
                end
                ptd_pkg::ACT_DEC_OBJ:
                begin
                    objects_decoded++;
                    expected_pixels.push_back(decoded_pixel(it, 0));
                end
                default:
                begin
                    rows_decoded++;
                    for (int c = 0; c < 8; c++)
                        expected_pixels.push_back(decoded_pixel(it, c));
                end
            endcase
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: colour %h column %0d last %0d",
                             got.colour, got.column, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.colour !== want.colour || got.column !== want.column ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: expected %h col %0d last %0d, got %h col %0d last %0d",
                             pixels_checked, want.colour, want.column, want.last,
                             got.colour, got.column, got.last);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    pixel_scoreboard sb;
    bit              vram_set [ptd_pkg::VRAM_BYTES];
    bit              pal_set [ptd_pkg::PAL_DEPTH];
    decode_item_t    recent_tiles [$];
    bit              send_rush;
    bit              take_rush;
    int              items_sent;
    int              colour_writes;
    int              drains;

    paletted_tile_pixel_decoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int idle_cycles(bit rush);
        return rush ? 0 : $urandom_range(0, 13);
    endfunction

    // Every field random; callers overwrite the ones that matter for the item.
    function automatic decode_item_t random_item();
        decode_item_t it;
        it.action = 2'($urandom_range(0, 3));
        it.write_address = 16'($urandom);
        it.write_data = 16'($urandom);
        it.tile_addr = 16'($urandom);
        it.tile_idx = 10'($urandom);
        it.palette_bank = 4'($urandom);
        it.eight_bpp = 1'($urandom);
        it.pixel_x = 3'($urandom);
        it.pixel_y = 3'($urandom);
        it.hflip = 1'($urandom);
        it.vflip = 1'($urandom);
        return it;
    endfunction

    function automatic decode_item_t write_item(logic [1:0] act, logic [15:0] addr,
                                                logic [15:0] data);
        decode_item_t it;
        it = random_item();
        it.action = act;
        it.write_address = addr;
        it.write_data = data;
        return it;
    endfunction

    function automatic decode_item_t row_item(logic [15:0] base, logic [9:0] tnum,
                                              logic [3:0] bank, logic eight, logic [2:0] py,
                                              logic hf, logic vf);
        decode_item_t it;
        it = random_item();
        it.action = ptd_pkg::ACT_DEC_BG;
        it.tile_addr = base;
        it.tile_idx = tnum;
        it.palette_bank = bank;
        it.eight_bpp = eight;
        it.pixel_y = py;
        it.hflip = hf;
        it.vflip = vf;
        return it;
    endfunction

    function automatic decode_item_t object_item(logic [15:0] base, logic [3:0] bank,
                                                 logic eight, logic [2:0] px, logic [2:0] py);
        decode_item_t it;
        it = random_item();
        it.action = ptd_pkg::ACT_DEC_OBJ;
        it.tile_addr = base;
        it.palette_bank = bank;
        it.eight_bpp = eight;
        it.pixel_x = px;
        it.pixel_y = py;
        return it;
    endfunction

    // Sender: optional gap, then hold the item until the core takes it.
    task automatic send_item(decode_item_t it);
        int gap;
        gap = idle_cycles(send_rush);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {1'b0, it.vflip, it.hflip, it.pixel_y, it.pixel_x, it.eight_bpp,
                    it.palette_bank, it.tile_idx, it.tile_addr, it.write_data,
                    it.write_address};
        do @(posedge clk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
        if (it.action == ptd_pkg::ACT_WR_VRAM)
            vram_set[int'(it.write_address) % ptd_pkg::VRAM_BYTES] = 1'b1;
        if (it.action == ptd_pkg::ACT_WR_PAL)
            pal_set[it.write_address[ptd_pkg::PAL_AW-1:0]] = 1'b1;
    endtask

    // A decode only goes out once every byte it reads, and the palette entry of every nonzero index, has been written.
    task automatic issue(decode_item_t it);
        int          slots;
        int          index;
        int          entry;
        int          addr;
        logic [15:0] data;
        if (it.action == ptd_pkg::ACT_DEC_BG || it.action == ptd_pkg::ACT_DEC_OBJ)
        begin
            slots = (it.action == ptd_pkg::ACT_DEC_BG) ? 8 : 1;
            for (int c = 0; c < slots; c++)
            begin
                addr = sb.source_address(it, c);
                if (!vram_set[addr])
                begin
                    data = 16'($urandom);
                    if ($urandom_range(0, 7) == 0)
                        data[7:0] = 8'h00;
                    send_item(write_item(ptd_pkg::ACT_WR_VRAM, 16'(addr), data));
                end
            end
            for (int c = 0; c < slots; c++)
            begin
                sb.palette_source(it, c, index, entry);
                if (index != 0 && !pal_set[entry])
                    send_item(write_item(ptd_pkg::ACT_WR_PAL,
                                         {7'($urandom), 9'(entry)}, 16'($urandom)));
            end
        end
        send_item(it);
    endtask

    // Hold the input off until every owed pixel has arrived and the core has settled.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        drains++;
    endtask

    task automatic write_transparent(logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.transparent_colour = value;
        colour_writes++;
    endtask

    task automatic run_directed();
        issue(write_item(ptd_pkg::ACT_WR_VRAM, 16'h0000, 16'hff00));
        issue(write_item(ptd_pkg::ACT_WR_VRAM, 16'hffff, 16'h00ff));
        issue(write_item(ptd_pkg::ACT_WR_PAL, 16'hffff, 16'hffff));
        issue(write_item(ptd_pkg::ACT_WR_PAL, 16'h0000, 16'h0000));
        // Row that runs past the top of video memory.
        issue(row_item(16'hffff, 10'h3ff, 4'hf, 1'b0, 3'd7, 1'b0, 1'b0));
        issue(row_item(16'h0000, 10'h000, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0));
        issue(row_item(16'h0000, 10'h000, 4'h0, 1'b0, 3'd0, 1'b1, 1'b0));
        issue(row_item(16'h0000, 10'h000, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1));
        issue(row_item(16'h0000, 10'h000, 4'h0, 1'b0, 3'd7, 1'b1, 1'b1));
        issue(row_item(16'hfff0, 10'h3ff, 4'hf, 1'b1, 3'd7, 1'b1, 1'b1));
        issue(row_item(16'hffff, 10'h000, 4'h0, 1'b1, 3'd0, 1'b0, 1'b0));
        issue(row_item(16'h1234, 10'h155, 4'h5, 1'b1, 3'd3, 1'b0, 1'b0));
        // Object pixel past the top of video memory, in the top palette bank.
        issue(object_item(16'hffff, 4'hf, 1'b0, 3'd7, 3'd7));
        issue(object_item(16'h0000, 4'h0, 1'b0, 3'd0, 3'd0));
        issue(object_item(16'hffff, 4'h0, 1'b1, 3'd0, 3'd0));
        issue(object_item(16'hffff, 4'h0, 1'b1, 3'd7, 3'd7));
        issue(object_item(16'h0000, 4'h3, 1'b1, 3'd0, 3'd0));
        issue(write_item(ptd_pkg::ACT_WR_VRAM, 16'h0001, 16'h1234));
        issue(row_item(16'h0000, 10'h000, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0));
    endtask

    task automatic run_random(int count);
        int           start;
        int           pick;
        int           addr;
        decode_item_t it;
        decode_item_t r;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(0, 24) == 0)
                send_rush = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 49) == 0)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                issue(write_item(ptd_pkg::ACT_WR_VRAM, 16'($urandom), 16'($urandom)));
            else if (pick < 18)
                issue(write_item(ptd_pkg::ACT_WR_PAL, 16'($urandom), 16'($urandom)));
            else if (pick < 24 && recent_tiles.size() > 0)
            begin
                r = recent_tiles[$urandom_range(0, recent_tiles.size() - 1)];
                addr = sb.source_address(r, $urandom_range(0, 7));
                issue(write_item(ptd_pkg::ACT_WR_VRAM, 16'(addr), 16'($urandom)));
            end
            else
            begin
                it = random_item();
                it.action = ($urandom_range(0, 4) < 3) ? ptd_pkg::ACT_DEC_BG : ptd_pkg::ACT_DEC_OBJ;
                // Revisiting a known tile keeps most decodes free of set-up writes.
                if (recent_tiles.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    r = recent_tiles[$urandom_range(0, recent_tiles.size() - 1)];
                    it.tile_addr = r.tile_addr;
                    it.tile_idx = r.tile_idx;
                    it.eight_bpp = r.eight_bpp;
                    if ($urandom_range(0, 1) == 1)
                        it.palette_bank = r.palette_bank;
                end
                issue(it);
                recent_tiles.push_back(it);
                if (recent_tiles.size() > 8)
                    void'(recent_tiles.pop_front());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel({m_tdata[15:0], m_tdata[18:16], m_tlast});
    end

    // Receiver: stall before each pixel, sometimes not at all for a stretch.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        m_tready = 1'b0;
        forever
        begin
            if (taken % 20 == 0)
                take_rush = ($urandom_range(0, 3) == 0);
            stall = idle_cycles(take_rush);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(rst_n && m_tvalid));
            taken++;
        end
    end

    initial
    begin
        logic [15:0] colour_value;
        sb = new();
        items_sent = 0;
        colour_writes = 0;
        drains = 0;
        send_rush = 1'b0;
        take_rush = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'h0000;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: colour_value = 16'h0000;
                1: colour_value = 16'hffff;
                default: colour_value = 16'($urandom);
            endcase
            write_transparent(colour_value);
            run_random(65);
        end
        drain();

        $display("%0d items: %0d background rows, %0d object pixels, %0d pixels checked",
                 items_sent, sb.rows_decoded, sb.objects_decoded, sb.pixels_checked);
        $display("transparent colour set %0d times, input held off until empty %0d times",
                 colour_writes, drains);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ptd_pkg.sv
design/ptd_ram.sv
design/ptd_agu.sv
design/paletted_tile_pixel_decoder_core.sv
dv/tb_top.sv
